>>> src/form_field_percent_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Form field percent decoder: assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FORM_FIELD_PERCENT_DECODER_UNIT_DEFINES_SVH
`define FORM_FIELD_PERCENT_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define FFPD_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ffpd assertion failed");
// antecedent implies consequent in the next cycle
`define FFPD_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ffpd assertion failed");
`else
`define FFPD_ASSERT_IMP(label, ck, rs, ante, cons)
`define FFPD_ASSERT_NXT(label, ck, rs, ante, cons)
`endif
`endif

>>> src/ffpd_pkg.sv
// ----------------------------------------------------------------------------
// Form field percent decoder package
// Types, codes and character constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package ffpd_pkg;

  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_MISSING    = 3'd1,
    ST_BAD_ESCAPE = 3'd2,
    ST_ZERO       = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_MATCH = 2'd0,
    PH_SKIP  = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } escape_t;

  localparam logic [1:0] CFG_KEY_TEXT    = 2'd0;
  localparam logic [1:0] CFG_KEY_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_VALUE_LIMIT = 2'd2;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [63:0] KEY_TEXT_RESET    = 64'd1685287795;
  localparam logic [3:0]  KEY_LENGTH_RESET  = 4'd4;
  localparam logic [7:0]  VALUE_LIMIT_RESET = 8'd63;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // classified input beat
  typedef struct packed {
    logic [7:0] form_byte;
    logic       last_byte;
    logic       is_amp;
    logic       is_pct;
    logic       is_eq;
    logic       is_plus;
    logic       hex_ok;
    logic [3:0] hex_val;
  } item_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] value_byte;
    status_t    status;
    logic       run_end;
  } result_t;

  typedef struct packed {
    logic   pending;
    phase_t phase;
  } back_stat_t;

endpackage

>>> src/ffpd_in_if.sv
// ----------------------------------------------------------------------------
// Form byte channel
// Valid/ready channel carrying raw form body bytes.
// ----------------------------------------------------------------------------
interface ffpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] form_byte;
  logic       last_byte;

  modport source (output valid, output form_byte, output last_byte, input ready);
  modport sink   (input valid, input form_byte, input last_byte, output ready);
endinterface

>>> src/ffpd_out_if.sv
// ----------------------------------------------------------------------------
// Decoder result channel
// Valid/ready channel carrying decoded value bytes and the status beat.
// ----------------------------------------------------------------------------
interface ffpd_out_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [7:0] value_byte;
  logic [2:0] status;
  logic       run_end;

  modport source (output valid, output is_status, output value_byte, output status,
                  output run_end, input ready);
  modport sink   (input valid, input is_status, input value_byte, input status,
                  input run_end, output ready);
endinterface

>>> src/ffpd_front.sv
// ----------------------------------------------------------------------------
// Form field percent decoder: front end
// Accepts form bytes, classifies them and registers the result.
// ----------------------------------------------------------------------------
module ffpd_front (
  input  logic           clk,
  input  logic           rst,
  ffpd_in_if.sink        form_in,
  output logic           item_valid,
  output ffpd_pkg::item_t item,
  input  logic           item_ready
);

  ffpd_pkg::item_t cls;
  logic [7:0]      b;

  assign b = form_in.form_byte;

  always_comb begin
    cls.form_byte = b;
    cls.last_byte = form_in.last_byte;
    cls.is_amp    = (b == ffpd_pkg::CH_AMP);
    cls.is_pct    = (b == ffpd_pkg::CH_PERCENT);
    cls.is_eq     = (b == ffpd_pkg::CH_EQUAL);
    cls.is_plus   = (b == ffpd_pkg::CH_PLUS);
    cls.hex_ok    = 1'b0;
    cls.hex_val   = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = b[3:0] + 4'd9;
    end
  end

  assign form_in.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (form_in.ready) begin
      item_valid <= form_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (form_in.valid && form_in.ready) begin
      item <= cls;
    end
  end

endmodule

>>> src/ffpd_queue.sv
// ----------------------------------------------------------------------------
// Form field percent decoder: item queue
// Short FIFO between the front end and the decode back end.
// ----------------------------------------------------------------------------
module ffpd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ffpd_pkg::item_t in_item,
  output logic            in_ready,
  output logic            out_valid,
  output ffpd_pkg::item_t out_item,
  input  logic            out_ready
);

  ffpd_pkg::item_t              mem [ffpd_pkg::QUEUE_DEPTH];
  logic [ffpd_pkg::QPTR_W-1:0]  wr_ptr;
  logic [ffpd_pkg::QPTR_W-1:0]  rd_ptr;
  logic [ffpd_pkg::QPTR_W:0]    count;
  logic                         push;
  logic                         pop;

  assign in_ready  = (count != (ffpd_pkg::QPTR_W+1)'(ffpd_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

>>> src/ffpd_back.sv
// ----------------------------------------------------------------------------
// Form field percent decoder: back end
// Key match, value decode and status, one queued byte per cycle unless the
// output register is stalled or a status beat is held behind a value byte.
// ----------------------------------------------------------------------------
module ffpd_back #(
  parameter int KEY_MAX_CHARS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [KEY_MAX_CHARS*8-1:0] key_text,
  input  logic [3:0]                 key_length,
  input  logic [7:0]                 value_limit,
  input  logic                       item_valid,
  input  ffpd_pkg::item_t            item,
  output logic                       item_ready,
  ffpd_out_if.source                 result_out,
  output ffpd_pkg::back_stat_t       stat
);

  localparam int KIW = (KEY_MAX_CHARS > 1) ? $clog2(KEY_MAX_CHARS) : 1;

  ffpd_pkg::phase_t  phase, phase_next;
  ffpd_pkg::escape_t escape_step, escape_step_next;
  ffpd_pkg::status_t outcome, outcome_next;
  logic [3:0]        key_position, key_position_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic [7:0]        decoded_count, decoded_count_next;

  ffpd_pkg::result_t out_res, out_res_next;
  ffpd_pkg::result_t pend_res, pend_res_next;
  logic              out_valid, out_valid_next;
  logic              pend_valid, pend_valid_next;

  logic              slot_free;
  logic              pop;
  logic [3:0]        klen;
  logic [7:0]        kc;
  logic              dec_go;
  logic [7:0]        dec_v;
  logic              emit;
  ffpd_pkg::status_t code;
  ffpd_pkg::result_t val_res;
  ffpd_pkg::result_t sts_res;

  assign slot_free  = !out_valid || result_out.ready;
  assign pop        = item_valid && !pend_valid && slot_free;
  assign item_ready = !pend_valid && slot_free;
  assign klen       = (key_length > 4'(KEY_MAX_CHARS)) ? 4'(KEY_MAX_CHARS) : key_length;
  assign kc         = key_text[key_position[KIW-1:0]*8 +: 8];

  always_comb begin
    phase_next         = phase;
    escape_step_next   = escape_step;
    outcome_next       = outcome;
    key_position_next  = key_position;
    high_nibble_next   = high_nibble;
    decoded_count_next = decoded_count;
    dec_go             = 1'b0;
    dec_v              = item.form_byte;
    emit               = 1'b0;
    code               = ffpd_pkg::ST_MISSING;

    if (pop) begin
      case (phase)
        ffpd_pkg::PH_MATCH, ffpd_pkg::PH_SKIP: begin
          if (item.is_amp) begin
            phase_next        = ffpd_pkg::PH_MATCH;
            key_position_next = 4'd0;
          end else if (phase == ffpd_pkg::PH_MATCH) begin
            if (key_position < klen) begin
              if (item.form_byte == kc) key_position_next = key_position + 4'd1;
              else phase_next = ffpd_pkg::PH_SKIP;
            end else if (item.is_eq) begin
              phase_next         = ffpd_pkg::PH_VALUE;
              escape_step_next   = ffpd_pkg::ESC_NONE;
              decoded_count_next = 8'd0;
            end else begin
              phase_next = ffpd_pkg::PH_SKIP;
            end
          end
        end
        ffpd_pkg::PH_VALUE: begin
          if (item.is_amp) begin
            phase_next       = ffpd_pkg::PH_DONE;
            escape_step_next = ffpd_pkg::ESC_NONE;
            outcome_next     = (escape_step != ffpd_pkg::ESC_NONE) ?
                               ffpd_pkg::ST_BAD_ESCAPE : ffpd_pkg::ST_FOUND;
          end else if (escape_step != ffpd_pkg::ESC_NONE) begin
            if (!item.hex_ok) begin
              phase_next       = ffpd_pkg::PH_DONE;
              escape_step_next = ffpd_pkg::ESC_NONE;
              outcome_next     = ffpd_pkg::ST_BAD_ESCAPE;
            end else if (escape_step == ffpd_pkg::ESC_HIGH) begin
              high_nibble_next = item.hex_val;
              escape_step_next = ffpd_pkg::ESC_LOW;
            end else begin
              escape_step_next = ffpd_pkg::ESC_NONE;
              dec_go           = 1'b1;
              dec_v            = {high_nibble, item.hex_val};
            end
          end else if (item.is_pct) begin
            escape_step_next = ffpd_pkg::ESC_HIGH;
          end else begin
            dec_go = 1'b1;
            dec_v  = item.is_plus ? ffpd_pkg::CH_SPACE : item.form_byte;
          end
        end
        default: begin
        end
      endcase

      if (dec_go) begin
        if (decoded_count >= value_limit) begin
          phase_next       = ffpd_pkg::PH_DONE;
          escape_step_next = ffpd_pkg::ESC_NONE;
          outcome_next     = ffpd_pkg::ST_TOO_LONG;
        end else if (dec_v == 8'd0) begin
          phase_next       = ffpd_pkg::PH_DONE;
          escape_step_next = ffpd_pkg::ESC_NONE;
          outcome_next     = ffpd_pkg::ST_ZERO;
        end else begin
          decoded_count_next = decoded_count + 8'd1;
          emit               = 1'b1;
        end
      end

      if (phase_next == ffpd_pkg::PH_VALUE) begin
        code = (escape_step_next != ffpd_pkg::ESC_NONE) ?
               ffpd_pkg::ST_BAD_ESCAPE : ffpd_pkg::ST_FOUND;
      end else if (phase_next == ffpd_pkg::PH_DONE) begin
        code = outcome_next;
      end

      if (item.last_byte) begin
        phase_next         = ffpd_pkg::PH_MATCH;
        escape_step_next   = ffpd_pkg::ESC_NONE;
        outcome_next       = ffpd_pkg::ST_MISSING;
        key_position_next  = 4'd0;
        high_nibble_next   = 4'd0;
        decoded_count_next = 8'd0;
      end
    end
  end

  always_comb begin
    val_res.is_status  = 1'b0;
    val_res.value_byte = dec_v;
    val_res.status     = ffpd_pkg::ST_FOUND;
    val_res.run_end    = 1'b0;
    sts_res.is_status  = 1'b1;
    sts_res.value_byte = 8'd0;
    sts_res.status     = code;
    sts_res.run_end    = 1'b1;

    out_res_next    = out_res;
    out_valid_next  = out_valid && !result_out.ready;
    pend_res_next   = pend_res;
    pend_valid_next = pend_valid;

    if (pend_valid && slot_free) begin
      out_res_next    = pend_res;
      out_valid_next  = 1'b1;
      pend_valid_next = 1'b0;
    end else if (pop) begin
      if (emit) begin
        out_res_next   = val_res;
        out_valid_next = 1'b1;
        if (item.last_byte) begin
          pend_res_next   = sts_res;
          pend_valid_next = 1'b1;
        end
      end else if (item.last_byte) begin
        out_res_next   = sts_res;
        out_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ffpd_pkg::PH_MATCH;
      escape_step   <= ffpd_pkg::ESC_NONE;
      outcome       <= ffpd_pkg::ST_MISSING;
      key_position  <= 4'd0;
      high_nibble   <= 4'd0;
      decoded_count <= 8'd0;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      phase         <= phase_next;
      escape_step   <= escape_step_next;
      outcome       <= outcome_next;
      key_position  <= key_position_next;
      high_nibble   <= high_nibble_next;
      decoded_count <= decoded_count_next;
      out_valid     <= out_valid_next;
      pend_valid    <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_res  <= out_res_next;
    pend_res <= pend_res_next;
  end

  assign result_out.valid      = out_valid;
  assign result_out.is_status  = out_res.is_status;
  assign result_out.value_byte = out_res.value_byte;
  assign result_out.status     = out_res.status;
  assign result_out.run_end    = out_res.run_end;

  assign stat.pending = pend_valid;
  assign stat.phase   = phase;

endmodule

>>> src/form_field_percent_decoder_unit.sv
// ----------------------------------------------------------------------------
// Form field percent decoder
// Scans a URL-encoded form body for the first '&'-separated segment that
// starts with the configured key and '=', and streams that value decoded
// ('+' to space, %HH to a byte), then one status beat on the last byte.
// Throughput is one form byte per cycle while the output is ready. A byte
// that yields both a value byte and the status beat holds the status beat
// in a pending register behind the single output register, and the back
// end takes no byte until it moves on. An accepted byte passes the classify
// register, the two-entry queue and the output register. Configuration
// takes effect for bytes that reach the back end after the write.
// ----------------------------------------------------------------------------
`include "form_field_percent_decoder_unit_defines.svh"

module form_field_percent_decoder_unit #(
  parameter int KEY_MAX_CHARS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  ffpd_in_if.sink                           form_in,
  ffpd_out_if.source                        result_out,
  input  logic                              cfg_we,
  input  logic [ffpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [KEY_MAX_CHARS*8-1:0] key_text;
  logic [3:0]                 key_length;
  logic [7:0]                 value_limit;

  logic                 f_valid;
  ffpd_pkg::item_t      f_item;
  logic                 f_ready;
  logic                 q_valid;
  ffpd_pkg::item_t      q_item;
  logic                 q_ready;
  ffpd_pkg::back_stat_t back_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_text    <= ffpd_pkg::KEY_TEXT_RESET[KEY_MAX_CHARS*8-1:0];
      key_length  <= ffpd_pkg::KEY_LENGTH_RESET;
      value_limit <= ffpd_pkg::VALUE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ffpd_pkg::CFG_KEY_TEXT:    key_text    <= cfg_data[KEY_MAX_CHARS*8-1:0];
        ffpd_pkg::CFG_KEY_LENGTH:  key_length  <= cfg_data[3:0];
        ffpd_pkg::CFG_VALUE_LIMIT: value_limit <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  ffpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .form_in    (form_in),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  ffpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .in_ready  (f_ready),
    .out_valid (q_valid),
    .out_item  (q_item),
    .out_ready (q_ready)
  );

  ffpd_back #(
    .KEY_MAX_CHARS (KEY_MAX_CHARS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .key_text    (key_text),
    .key_length  (key_length),
    .value_limit (value_limit),
    .item_valid  (q_valid),
    .item        (q_item),
    .item_ready  (q_ready),
    .result_out  (result_out),
    .stat        (back_stat)
  );

  `FFPD_ASSERT_IMP(a_pend_behind_value, clk, rst, back_stat.pending, result_out.valid && !result_out.is_status)
  `FFPD_ASSERT_NXT(a_pend_holds, clk, rst, back_stat.pending && !result_out.ready, back_stat.pending)
  `FFPD_ASSERT_IMP(a_value_beat_fields, clk, rst, result_out.valid && !result_out.is_status, !result_out.run_end && result_out.status == ffpd_pkg::ST_FOUND)
  `FFPD_ASSERT_IMP(a_status_beat_fields, clk, rst, result_out.valid && result_out.is_status, result_out.run_end && result_out.value_byte == 8'd0)

endmodule
